### hdl/equinoctial_to_keplerian_assert.svh
// Assertion macros for the equinoctial to Keplerian converter.
// Included by the top level; no other dependencies.
`ifndef EQUINOCTIAL_TO_KEPLERIAN_ASSERT_SVH
`define EQUINOCTIAL_TO_KEPLERIAN_ASSERT_SVH
`ifndef SYNTH
`define E2K_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2k assertion failed");
`define E2K_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2k assertion failed");
`else
`define E2K_ASSERT_IMPL(label, clk, rst, ante, cons)
`define E2K_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/e2k_pkg.sv
// Shared constants, types and the arctangent table of the converter.
// No dependencies.
package e2k_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int SQRT_CELLS   = 32;
  localparam int DIV_CELLS    = 33;
  localparam int NORM_CELLS   = 6;

  localparam logic [63:0]        ONE_Q60   = 64'h1000_0000_0000_0000;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
  localparam logic signed [33:0] PI_Q      = 34'sd843314857;
  localparam logic [30:0]        INC_MAX   = 31'd843314857;
  localparam logic signed [62:0] ONE_Q24   = 63'sd16777216;
  localparam logic signed [31:0] SMA_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMA_MIN   = 32'sh8000_0000;
  localparam logic [5:0]         ATAN_DEPTH = 6'd40;

  localparam logic [31:0] ATAN_TAB [40] = '{
    32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
    32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
    32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64, 32'd32,
    32'd16, 32'd8, 32'd4, 32'd2, 32'd1,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SAT     = 2'd1,
    STATUS_ECC_ONE = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [62:0] rem;
    logic [62:0] d;
    logic [32:0] q;
    logic        neg;
    logic        over;
    logic        eq_one;
  } div_t;

  typedef struct packed {
    logic               zero;
    logic signed [62:0] x;
    logic signed [62:0] y;
    logic [62:0]        m;
  } norm_t;

  typedef struct packed {
    logic               zero;
    logic signed [62:0] x;
    logic signed [62:0] y;
    logic signed [31:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] semi_major_axis;
    logic [31:0]        eccentricity;
    logic [30:0]        inclination;
    logic signed [31:0] node_longitude;
    logic signed [31:0] periapsis_argument;
    logic signed [31:0] true_anomaly;
    status_t            status;
  } out_item_t;

  function automatic logic signed [31:0] atan_at(input logic [5:0] step);
    if (step < ATAN_DEPTH) begin
      atan_at = ATAN_TAB[step];
    end else begin
      atan_at = '0;
    end
  endfunction

endpackage

### hdl/e2k_if.sv
// Valid/ready channel interfaces for the element sets in and out.
// Standalone; payload fields follow the element definitions.
interface e2k_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        semi_latus_rectum;
  logic signed [31:0] ecc_f;
  logic signed [31:0] ecc_g;
  logic signed [31:0] node_h;
  logic signed [31:0] node_k;
  logic signed [31:0] true_longitude;

  modport source (output valid, semi_latus_rectum, ecc_f, ecc_g, node_h, node_k,
                  true_longitude, input ready);
  modport sink (input valid, semi_latus_rectum, ecc_f, ecc_g, node_h, node_k,
                true_longitude, output ready);
endinterface

interface e2k_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] semi_major_axis;
  logic [31:0]        eccentricity;
  logic [30:0]        inclination;
  logic signed [31:0] node_longitude;
  logic signed [31:0] periapsis_argument;
  logic signed [31:0] true_anomaly;
  logic [1:0]         status;

  modport source (output valid, semi_major_axis, eccentricity, inclination,
                  node_longitude, periapsis_argument, true_anomaly, status,
                  input ready);
  modport sink (input valid, semi_major_axis, eccentricity, inclination,
                node_longitude, periapsis_argument, true_anomaly, status,
                output ready);
endinterface

### hdl/e2k_sqrt_cell.sv
// One digit of the pipelined square root: retires one result bit per cell.
// Depends on e2k_pkg.
module e2k_sqrt_cell (
  input  logic           clk,
  input  logic           adv,
  input  e2k_pkg::sqrt_t cur,
  output e2k_pkg::sqrt_t nxt
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {cur.rem, cur.rad[63:62]};
    trial  = {2'b00, cur.root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxt.rad  <= {cur.rad[61:0], 2'b00};
      nxt.rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      nxt.root <= {cur.root[30:0], ge};
    end
  end

endmodule

### hdl/e2k_div_cell.sv
// One quotient bit of the restoring divider for the semi-major axis.
// Depends on e2k_pkg.
module e2k_div_cell (
  input  logic          clk,
  input  logic          adv,
  input  e2k_pkg::div_t cur,
  output e2k_pkg::div_t nxt
);

  logic [63:0] sh;
  logic        ge;

  always_comb begin
    sh = {cur.rem, 1'b0};
    ge = sh >= {1'b0, cur.d};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxt.rem    <= ge ? 63'(sh - {1'b0, cur.d}) : sh[62:0];
      nxt.d      <= cur.d;
      nxt.q      <= {cur.q[31:0], ge};
      nxt.neg    <= cur.neg;
      nxt.over   <= cur.over;
      nxt.eq_one <= cur.eq_one;
    end
  end

endmodule

### hdl/e2k_norm_cell.sv
// One binary step of the CORDIC input normalizer: shift left by amt if it fits.
// Depends on e2k_pkg.
module e2k_norm_cell (
  input  logic           clk,
  input  logic           adv,
  input  logic [5:0]     amt,
  input  e2k_pkg::norm_t cur,
  output e2k_pkg::norm_t nxt
);

  logic fits;

  always_comb begin
    fits = (cur.m >> (6'd60 - amt)) == '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxt.zero <= cur.zero;
      nxt.x    <= fits ? (cur.x <<< amt) : cur.x;
      nxt.y    <= fits ? (cur.y <<< amt) : cur.y;
      nxt.m    <= fits ? (cur.m << amt) : cur.m;
    end
  end

endmodule

### hdl/e2k_cordic_cell.sv
// One vectoring CORDIC iteration with angle accumulation in Q4.28.
// Depends on e2k_pkg (arctangent table).
module e2k_cordic_cell (
  input  logic             clk,
  input  logic             adv,
  input  logic [5:0]       step,
  input  e2k_pkg::cordic_t cur,
  output e2k_pkg::cordic_t nxt
);

  logic signed [62:0] xs;
  logic signed [62:0] ys;
  logic signed [31:0] a;

  always_comb begin
    xs = cur.x >>> step;
    ys = cur.y >>> step;
    a  = e2k_pkg::atan_at(step);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxt.zero <= cur.zero;
      if (cur.y > 63'sd0) begin
        nxt.x <= cur.x + ys;
        nxt.y <= cur.y - xs;
        nxt.z <= cur.z + a;
      end else begin
        nxt.x <= cur.x - ys;
        nxt.y <= cur.y + xs;
        nxt.z <= cur.z - a;
      end
    end
  end

endmodule

### hdl/equinoctial_to_keplerian.sv
// Modified equinoctial to Keplerian element converter, top level.
// Depends on e2k_pkg, e2k_if, the four cell modules and the assertion header.
//
// Fully pipelined: one element set is accepted every clock cycle while the skid
// stage is empty. The longest path is the 32-cell square root chain for |(h,k)|
// feeding the inclination CORDIC chain of CORDIC_STEPS cells; the divider and
// the other two angle chains run beside it. A one-entry skid stage behind the
// output register catches a result while the output waits; the input is closed
// while it is full. Retrograde is sampled as results leave the pipeline, so
// write it only while the block is empty.
`include "equinoctial_to_keplerian_assert.svh"

module equinoctial_to_keplerian (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  e2k_in_if.sink       equinoctial,
  e2k_out_if.source    keplerian
);

  localparam int ST_S     = 2;
  localparam int ST_ROOT  = ST_S + e2k_pkg::SQRT_CELLS + 1;
  localparam int ST_A     = ST_S + 1 + e2k_pkg::DIV_CELLS + 1;
  localparam int ST_PREP  = ST_ROOT + 1;
  localparam int ST_FOLD  = ST_PREP + e2k_pkg::NORM_CELLS + 1;
  localparam int ST_LAST  = ST_FOLD + e2k_pkg::CORDIC_STEPS;
  localparam int ECC_DLY  = ST_LAST - ST_ROOT;
  localparam int A_DLY    = ST_LAST - ST_A;
  localparam int L_DLY    = ST_LAST - ST_S;
  localparam int ANG_DLY  = ST_ROOT - ST_S;
  localparam int N_LANES  = 3;
  localparam int LANE_ZETA = 0;
  localparam int LANE_NODE = 1;
  localparam int LANE_INC  = 2;

  typedef struct packed {
    logic signed [31:0] f;
    logic signed [31:0] g;
    logic signed [31:0] h;
    logic signed [31:0] k;
  } ang_in_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic               sat;
    logic               eq_one;
  } a_res_t;

  logic                retrograde;
  logic                adv;
  logic [ST_LAST:1]    vld;

  logic [31:0]         p1;
  logic [62:0]         ff1, gg1, hh1, kk1;
  ang_in_t             ang1;
  logic signed [31:0]  l1;
  logic signed [63:0]  ff_w, gg_w, hh_w, kk_w;

  logic [31:0]         p2;
  logic [63:0]         s2, hk2;
  ang_in_t             ang2;
  logic signed [31:0]  l2;

  e2k_pkg::sqrt_t      sq_s [e2k_pkg::SQRT_CELLS+1];
  e2k_pkg::sqrt_t      sq_h [e2k_pkg::SQRT_CELLS+1];
  logic [31:0]         ecc_q;
  logic [31:0]         tmp_q;

  e2k_pkg::div_t       dv_front;
  e2k_pkg::div_t       dv [e2k_pkg::DIV_CELLS+1];
  logic [62:0]         d_w;
  logic [63:0]         sh_w;
  logic                rnd;
  logic [33:0]         qr;
  a_res_t              a_w;
  a_res_t              a_q;

  logic [31:0]         ecc_dly [ECC_DLY];
  a_res_t              a_dly [A_DLY];
  logic signed [31:0]  l_dly [L_DLY];
  ang_in_t             ang_dly [ANG_DLY];

  logic signed [62:0]  lx [N_LANES];
  logic signed [62:0]  ly [N_LANES];
  e2k_pkg::norm_t      prep_q [N_LANES];
  e2k_pkg::norm_t      nm [N_LANES][e2k_pkg::NORM_CELLS+1];
  e2k_pkg::cordic_t    fold_q [N_LANES];
  e2k_pkg::cordic_t    cr [N_LANES][e2k_pkg::CORDIC_STEPS+1];

  logic signed [31:0]  zeta, node, z_inc;
  logic signed [33:0]  inc2, inc_r;
  logic [30:0]         inc_c;
  logic signed [32:0]  peri_w, nu_w;
  logic signed [31:0]  nu_s;
  logic                nu_sat;
  e2k_pkg::out_item_t  res;

  e2k_pkg::out_item_t  out_data, skid_data;
  logic                out_valid, skid_valid;
  logic                out_fire;
  logic                out_stall;
  logic                out_ecc_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      retrograde <= 1'b0;
    end else if (cfg_we) begin
      retrograde <= cfg_wdata;
    end
  end

  assign adv = !skid_valid;
  assign equinoctial.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_LAST-1:1], equinoctial.valid};
    end
  end

  always_comb begin
    ff_w = equinoctial.ecc_f * equinoctial.ecc_f;
    gg_w = equinoctial.ecc_g * equinoctial.ecc_g;
    hh_w = equinoctial.node_h * equinoctial.node_h;
    kk_w = equinoctial.node_k * equinoctial.node_k;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1     <= equinoctial.semi_latus_rectum;
      ff1    <= ff_w[62:0];
      gg1    <= gg_w[62:0];
      hh1    <= hh_w[62:0];
      kk1    <= kk_w[62:0];
      ang1.f <= equinoctial.ecc_f;
      ang1.g <= equinoctial.ecc_g;
      ang1.h <= equinoctial.node_h;
      ang1.k <= equinoctial.node_k;
      l1     <= equinoctial.true_longitude;
      p2     <= p1;
      s2     <= {1'b0, ff1} + {1'b0, gg1};
      hk2    <= {1'b0, hh1} + {1'b0, kk1};
      ang2   <= ang1;
      l2     <= l1;
    end
  end

  // square roots of f^2+g^2 and h^2+k^2
  assign sq_s[0] = '{rad: s2, rem: '0, root: '0};
  assign sq_h[0] = '{rad: hk2, rem: '0, root: '0};

  for (genvar j = 0; j < e2k_pkg::SQRT_CELLS; j++) begin : g_sqrt
    e2k_sqrt_cell u_sq_s (.clk(clk), .adv(adv), .cur(sq_s[j]), .nxt(sq_s[j+1]));
    e2k_sqrt_cell u_sq_h (.clk(clk), .adv(adv), .cur(sq_h[j]), .nxt(sq_h[j+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ecc_q <= sq_s[e2k_pkg::SQRT_CELLS].root + 32'(sq_s[e2k_pkg::SQRT_CELLS].rem >
               {2'b00, sq_s[e2k_pkg::SQRT_CELLS].root});
      tmp_q <= sq_h[e2k_pkg::SQRT_CELLS].root + 32'(sq_h[e2k_pkg::SQRT_CELLS].rem >
               {2'b00, sq_h[e2k_pkg::SQRT_CELLS].root});
    end
  end

  // divider p * 2^60 / |2^60 - S|
  always_comb begin
    if (s2 > e2k_pkg::ONE_Q60) begin
      d_w = 63'(s2 - e2k_pkg::ONE_Q60);
    end else begin
      d_w = 63'(e2k_pkg::ONE_Q60 - s2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_front.rem    <= {4'b0000, p2, 27'd0};
      dv_front.d      <= d_w;
      dv_front.q      <= '0;
      dv_front.neg    <= s2 > e2k_pkg::ONE_Q60;
      dv_front.over   <= {4'b0000, p2, 27'd0} >= d_w;
      dv_front.eq_one <= s2 == e2k_pkg::ONE_Q60;
    end
  end

  assign dv[0] = dv_front;

  for (genvar j = 0; j < e2k_pkg::DIV_CELLS; j++) begin : g_div
    e2k_div_cell u_div (.clk(clk), .adv(adv), .cur(dv[j]), .nxt(dv[j+1]));
  end

  always_comb begin
    sh_w = {dv[e2k_pkg::DIV_CELLS].rem, 1'b0};
    rnd  = sh_w >= {1'b0, dv[e2k_pkg::DIV_CELLS].d};
    qr   = {1'b0, dv[e2k_pkg::DIV_CELLS].q} + 34'(rnd);
    a_w.eq_one = dv[e2k_pkg::DIV_CELLS].eq_one;
    priority if (dv[e2k_pkg::DIV_CELLS].eq_one) begin
      a_w.a   = e2k_pkg::SMA_MAX;
      a_w.sat = 1'b0;
    end else if (dv[e2k_pkg::DIV_CELLS].neg) begin
      if (dv[e2k_pkg::DIV_CELLS].over || qr > 34'h0_8000_0000) begin
        a_w.a   = e2k_pkg::SMA_MIN;
        a_w.sat = 1'b1;
      end else begin
        a_w.a   = 32'(-qr);
        a_w.sat = 1'b0;
      end
    end else begin
      if (dv[e2k_pkg::DIV_CELLS].over || qr > 34'h0_7FFF_FFFF) begin
        a_w.a   = e2k_pkg::SMA_MAX;
        a_w.sat = 1'b1;
      end else begin
        a_w.a   = qr[31:0];
        a_w.sat = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q <= a_w;
    end
  end

  // align side results with the end of the CORDIC chains
  always_ff @(posedge clk) begin
    if (adv) begin
      ecc_dly[0] <= ecc_q;
      for (int i = 1; i < ECC_DLY; i++) ecc_dly[i] <= ecc_dly[i-1];
      a_dly[0] <= a_q;
      for (int i = 1; i < A_DLY; i++) a_dly[i] <= a_dly[i-1];
      l_dly[0] <= l2;
      for (int i = 1; i < L_DLY; i++) l_dly[i] <= l_dly[i-1];
      ang_dly[0] <= ang2;
      for (int i = 1; i < ANG_DLY; i++) ang_dly[i] <= ang_dly[i-1];
    end
  end

  always_comb begin
    lx[LANE_ZETA] = {{31{ang_dly[ANG_DLY-1].f[31]}}, ang_dly[ANG_DLY-1].f};
    ly[LANE_ZETA] = {{31{ang_dly[ANG_DLY-1].g[31]}}, ang_dly[ANG_DLY-1].g};
    lx[LANE_NODE] = {{31{ang_dly[ANG_DLY-1].h[31]}}, ang_dly[ANG_DLY-1].h};
    ly[LANE_NODE] = {{31{ang_dly[ANG_DLY-1].k[31]}}, ang_dly[ANG_DLY-1].k};
    lx[LANE_INC]  = e2k_pkg::ONE_Q24;
    ly[LANE_INC]  = {31'd0, tmp_q};
  end

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    logic [62:0] ax, ay, mx;

    always_comb begin
      ax = lx[l][62] ? 63'(-lx[l]) : 63'(lx[l]);
      ay = ly[l][62] ? 63'(-ly[l]) : 63'(ly[l]);
      mx = (ax > ay) ? ax : ay;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        prep_q[l].zero <= mx == '0;
        prep_q[l].x    <= lx[l];
        prep_q[l].y    <= ly[l];
        prep_q[l].m    <= mx;
      end
    end

    assign nm[l][0] = prep_q[l];

    for (genvar j = 0; j < e2k_pkg::NORM_CELLS; j++) begin : g_norm
      e2k_norm_cell u_norm (
        .clk(clk), .adv(adv), .amt(6'(32 >> j)), .cur(nm[l][j]), .nxt(nm[l][j+1])
      );
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fold_q[l].zero <= nm[l][e2k_pkg::NORM_CELLS].zero;
        if (nm[l][e2k_pkg::NORM_CELLS].x[62] && !nm[l][e2k_pkg::NORM_CELLS].y[62]) begin
          fold_q[l].x <= nm[l][e2k_pkg::NORM_CELLS].y;
          fold_q[l].y <= -nm[l][e2k_pkg::NORM_CELLS].x;
          fold_q[l].z <= e2k_pkg::HALF_PI_Q;
        end else if (nm[l][e2k_pkg::NORM_CELLS].x[62]) begin
          fold_q[l].x <= -nm[l][e2k_pkg::NORM_CELLS].y;
          fold_q[l].y <= nm[l][e2k_pkg::NORM_CELLS].x;
          fold_q[l].z <= -e2k_pkg::HALF_PI_Q;
        end else begin
          fold_q[l].x <= nm[l][e2k_pkg::NORM_CELLS].x;
          fold_q[l].y <= nm[l][e2k_pkg::NORM_CELLS].y;
          fold_q[l].z <= '0;
        end
      end
    end

    assign cr[l][0] = fold_q[l];

    for (genvar j = 0; j < e2k_pkg::CORDIC_STEPS; j++) begin : g_cordic
      e2k_cordic_cell u_cordic (
        .clk(clk), .adv(adv), .step(6'(j)), .cur(cr[l][j]), .nxt(cr[l][j+1])
      );
    end
  end

  // combine angles, saturate and pick status
  always_comb begin
    zeta  = cr[LANE_ZETA][e2k_pkg::CORDIC_STEPS].zero ? 32'sd0 :
            cr[LANE_ZETA][e2k_pkg::CORDIC_STEPS].z;
    node  = cr[LANE_NODE][e2k_pkg::CORDIC_STEPS].zero ? 32'sd0 :
            cr[LANE_NODE][e2k_pkg::CORDIC_STEPS].z;
    z_inc = cr[LANE_INC][e2k_pkg::CORDIC_STEPS].zero ? 32'sd0 :
            cr[LANE_INC][e2k_pkg::CORDIC_STEPS].z;
    inc2  = {z_inc[31], z_inc, 1'b0};
    inc_r = retrograde ? (e2k_pkg::PI_Q - inc2) : inc2;
    priority if (inc_r < 34'sd0) begin
      inc_c = '0;
    end else if (inc_r > e2k_pkg::PI_Q) begin
      inc_c = e2k_pkg::INC_MAX;
    end else begin
      inc_c = inc_r[30:0];
    end
    peri_w = retrograde ? ({zeta[31], zeta} + {node[31], node}) :
                          ({zeta[31], zeta} - {node[31], node});
    nu_w   = {l_dly[L_DLY-1][31], l_dly[L_DLY-1]} - {zeta[31], zeta};
    nu_sat = nu_w[32] != nu_w[31];
    priority if (!nu_w[32] && nu_w[31]) begin
      nu_s = e2k_pkg::SMA_MAX;
    end else if (nu_w[32] && !nu_w[31]) begin
      nu_s = e2k_pkg::SMA_MIN;
    end else begin
      nu_s = nu_w[31:0];
    end
    res.semi_major_axis    = a_dly[A_DLY-1].a;
    res.eccentricity       = ecc_dly[ECC_DLY-1];
    res.inclination        = inc_c;
    res.node_longitude     = node;
    res.periapsis_argument = peri_w[31:0];
    res.true_anomaly       = nu_s;
    priority if (a_dly[A_DLY-1].eq_one) begin
      res.status = e2k_pkg::STATUS_ECC_ONE;
    end else if (nu_sat || a_dly[A_DLY-1].sat) begin
      res.status = e2k_pkg::STATUS_SAT;
    end else begin
      res.status = e2k_pkg::STATUS_OK;
    end
  end

  // output register with skid stage
  assign out_fire = out_valid && keplerian.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (vld[ST_LAST]) begin
        if (!out_valid || out_fire) begin
          out_data  <= res;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign keplerian.valid              = out_valid;
  assign keplerian.semi_major_axis    = out_data.semi_major_axis;
  assign keplerian.eccentricity       = out_data.eccentricity;
  assign keplerian.inclination        = out_data.inclination;
  assign keplerian.node_longitude     = out_data.node_longitude;
  assign keplerian.periapsis_argument = out_data.periapsis_argument;
  assign keplerian.true_anomaly       = out_data.true_anomaly;
  assign keplerian.status             = out_data.status;

  assign out_stall   = out_valid && !keplerian.ready && !skid_valid && vld[ST_LAST];
  assign out_ecc_one = out_valid && out_data.status == e2k_pkg::STATUS_ECC_ONE;

  `E2K_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `E2K_ASSERT_NEXT(a_stall_fills_skid, clk, rst, out_stall, skid_valid)
  `E2K_ASSERT_IMPL(a_ecc_one_saturates, clk, rst, out_ecc_one, out_data.semi_major_axis == e2k_pkg::SMA_MAX)
  `E2K_ASSERT_IMPL(a_inc_in_range, clk, rst, out_valid, out_data.inclination <= e2k_pkg::INC_MAX)

endmodule
